[rtl/gbe_pkg.sv]
`timescale 1ns / 1ps

package gbe_pkg;

	// Default store size in bytes
	localparam int unsigned GBE_CAPACITY = 65536;

	// Field widths fixed by the interface
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned INDEX_W = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned LEN_W   = 17;

	// Function codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MOVE,
		S_RDWAIT,
		S_DONE
	} gbe_state_t;

	// Commands from the sequencer to the gap pointer unit
	typedef struct packed {
		logic go;   // start moving the gap to pos
		logic ins;  // one byte written at gap start, grow content
		logic rem;  // swallow cnt bytes past the gap
	} mv_cmd_t;

endpackage

[rtl/gbe_ram.sv]
`timescale 1ns / 1ps

module gbe_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/gbe_gap_mover.sv]
`timescale 1ns / 1ps

module gbe_gap_mover #(
	parameter int unsigned CAPACITY = gbe_pkg::GBE_CAPACITY,
	localparam int unsigned PW = $clog2(CAPACITY + 1),
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gbe_pkg::mv_cmd_t cmd,
	input  logic [PW-1:0]   pos,
	input  logic [PW-1:0]   cnt,
	output logic [PW-1:0]   gap_start,
	output logic [PW-1:0]   gap_end,
	output logic            idle,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr
);

	import gbe_pkg::*;

	logic [PW-1:0] gs_q, ge_q, rem_q;
	logic          left_q;
	logic          pend_s1;
	logic [AW-1:0] waddr_s1;
	logic [PW-1:0] gs_dec, ge_dec;
	logic          moving;

	assign gs_dec = gs_q - PW'(1);
	assign ge_dec = ge_q - PW'(1);
	assign moving = (rem_q != '0);

	// Left move copies gs-1 -> ge-1; right move copies ge -> gs.
	// Read goes out now, the matching write in the next cycle with RAM data.
	always_comb begin
		rd_en   = moving;
		rd_addr = left_q ? gs_dec[AW-1:0] : ge_q[AW-1:0];
		wr_en   = pend_s1;
		wr_addr = waddr_s1;
		idle    = !moving && !pend_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q    <= '0;
			ge_q    <= PW'(CAPACITY);
			rem_q   <= '0;
			left_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= moving;
			if (cmd.go) begin
				if (pos < gs_q) begin
					left_q <= 1'b1;
					rem_q  <= gs_q - pos;
				end else begin
					left_q <= 1'b0;
					rem_q  <= pos - gs_q;
				end
			end else if (moving) begin
				rem_q <= rem_q - PW'(1);
				if (left_q) begin
					gs_q <= gs_dec;
					ge_q <= ge_dec;
				end else begin
					gs_q <= gs_q + PW'(1);
					ge_q <= ge_q + PW'(1);
				end
			end else if (cmd.ins) begin
				gs_q <= gs_q + PW'(1);
			end else if (cmd.rem) begin
				ge_q <= ge_q + cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (moving) begin
			waddr_s1 <= left_q ? ge_dec[AW-1:0] : gs_q[AW-1:0];
		end
	end

	assign gap_start = gs_q;
	assign gap_end   = ge_q;

endmodule

[rtl/gap_buffer_engine.sv]
`timescale 1ns / 1ps

// Gap buffer of CAPACITY bytes holding an editable byte sequence. Each input
// transaction inserts one byte, removes a run, reads one byte or overwrites one
// byte at a logical index (gap not counted); each gives exactly one output
// transaction with the byte read, a status (ok, out of range, full) and the
// content length afterwards. Out of range and full cases, and overwrites,
// pass from the check state to the done state; reads add a wait state for
// the registered store read. Insert and remove first slide the gap to the
// index by copying one byte per cycle through the single byte RAM, then
// commit the edit once the mover is idle, which waits for the last copy
// write to drain. In every case the result is loaded into the output
// register once that register is free, and the input is ready again in the
// cycle after the result is loaded. One transaction is in flight at a time;
// a finished result waits in the output register while the next transaction
// is accepted. No clearing pass is needed after reset: only bytes written by
// inserts are ever read.
module gap_buffer_engine #(
	parameter int unsigned CAPACITY = gbe_pkg::GBE_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gbe_pkg::FUNC_W-1:0]    func,
	input  logic [gbe_pkg::INDEX_W-1:0]   index,
	input  logic [gbe_pkg::BYTE_W-1:0]    data_byte,
	input  logic [gbe_pkg::COUNT_W-1:0]   count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gbe_pkg::BYTE_W-1:0]    read_byte,
	output logic [gbe_pkg::STAT_W-1:0]    status,
	output logic [gbe_pkg::LEN_W-1:0]     content_length
);

	import gbe_pkg::*;

	// Pointer width holds CAPACITY itself; AW indexes the store.
	localparam int unsigned PW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);
	// Compare width: covers pointers and index + count
	localparam int unsigned CW = (PW > COUNT_W + 1) ? PW : COUNT_W + 1;

	gbe_state_t state_q, state_d;

	// Captured transaction
	logic [FUNC_W-1:0]  func_q;
	logic [INDEX_W-1:0] idx_q;
	logic [BYTE_W-1:0]  dat_q;
	logic [COUNT_W-1:0] cnt_q;

	// Result under construction
	logic [STAT_W-1:0] stat_q, stat_d;
	logic [BYTE_W-1:0] rd_q, rd_d;

	// Output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [LEN_W-1:0]  out_len_q;

	// Gap pointer unit
	mv_cmd_t       cmd;
	logic [PW-1:0] gap_start, gap_end;
	logic          mv_idle;
	logic          mv_rd_en, mv_wr_en;
	logic [AW-1:0] mv_rd_addr, mv_wr_addr;

	// Store ports
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	// Datapath helpers
	logic [PW-1:0] gap_len, len;
	logic [CW-1:0] len_c, idx_c, end_c, phys_c;
	logic          acc_in, load_out;
	logic          top_rd, top_wr;
	logic [AW-1:0] top_addr;

	assign gap_len = gap_end - gap_start;
	assign len     = PW'(CAPACITY) - gap_len;
	assign len_c   = CW'(len);
	assign idx_c   = CW'(idx_q);
	assign end_c   = idx_c + CW'(cnt_q);
	// Physical address for read / overwrite: skip the gap at or past its start
	assign phys_c  = (idx_c < CW'(gap_start)) ? idx_c : idx_c + CW'(gap_len);

	assign acc_in   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	gbe_gap_mover #(
		.CAPACITY (CAPACITY)
	) u_mover (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pos       (PW'(idx_q)),
		.cnt       (PW'(cnt_q)),
		.gap_start (gap_start),
		.gap_end   (gap_end),
		.idle      (mv_idle),
		.rd_en     (mv_rd_en),
		.rd_addr   (mv_rd_addr),
		.wr_en     (mv_wr_en),
		.wr_addr   (mv_wr_addr)
	);

	// Sequencer: check, move gap, apply edit or access store, deliver
	always_comb begin
		state_d  = state_q;
		stat_d   = stat_q;
		rd_d     = rd_q;
		cmd      = '0;
		top_rd   = 1'b0;
		top_wr   = 1'b0;
		top_addr = phys_c[AW-1:0];
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				stat_d  = ST_OK;
				rd_d    = '0;
				state_d = S_DONE;
				case (func_q)
					FN_INSERT: begin
						if (idx_c > len_c) begin
							stat_d = ST_RANGE;
						end else if (gap_start == gap_end) begin
							stat_d = ST_FULL;
						end else begin
							cmd.go  = 1'b1;
							state_d = S_MOVE;
						end
					end
					FN_REMOVE: begin
						if (end_c > len_c) begin
							stat_d = ST_RANGE;
						end else begin
							cmd.go  = 1'b1;
							state_d = S_MOVE;
						end
					end
					FN_READ: begin
						if (idx_c >= len_c) begin
							stat_d = ST_RANGE;
						end else begin
							top_rd  = 1'b1;
							state_d = S_RDWAIT;
						end
					end
					default: begin
						// overwrite
						if (idx_c >= len_c) begin
							stat_d = ST_RANGE;
						end else begin
							top_wr = 1'b1;
						end
					end
				endcase
			end
			S_MOVE: begin
				// Once the mover is idle the gap sits at the index: commit the edit
				if (mv_idle) begin
					if (func_q == FN_INSERT) begin
						cmd.ins  = 1'b1;
						top_wr   = 1'b1;
						top_addr = gap_start[AW-1:0];
					end else begin
						cmd.rem = 1'b1;
					end
					state_d = S_DONE;
				end
			end
			S_RDWAIT: begin
				rd_d    = ram_rdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Store port steering: the mover owns the ports while copying
	always_comb begin
		ram_re    = mv_rd_en || top_rd;
		ram_raddr = mv_rd_en ? mv_rd_addr : top_addr;
		ram_we    = mv_wr_en || top_wr;
		ram_waddr = mv_wr_en ? mv_wr_addr : top_addr;
		ram_wdata = mv_wr_en ? ram_rdata : dat_q;
	end

	gbe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			func_q <= func;
			idx_q  <= index;
			dat_q  <= data_byte;
			cnt_q  <= count;
		end
		stat_q <= stat_d;
		rd_q   <= rd_d;
		if (load_out) begin
			out_byte_q <= rd_q;
			out_stat_q <= stat_q;
			out_len_q  <= LEN_W'(len);
		end
	end

	assign out_valid      = out_valid_q;
	assign read_byte      = out_byte_q;
	assign status         = out_stat_q;
	assign content_length = out_len_q;

endmodule

[sim/gap_buffer_engine_tb.sv]
`timescale 1ns / 1ps

localparam int unsigned STORE_BYTES = gbe_pkg::GBE_CAPACITY;

typedef struct {
	logic [gbe_pkg::BYTE_W-1:0] rd;
	logic [gbe_pkg::STAT_W-1:0] st;
	logic [gbe_pkg::LEN_W-1:0]  len;
} edit_reply_t;

// Mirror of the gap buffer plus the queue of replies it still owes.
class gap_edit_board;
	logic [7:0]   store_bytes [STORE_BYTES];
	int unsigned  gap_lo;
	int unsigned  gap_hi;
	edit_reply_t  replies_due[$];
	int unsigned  errors;
	int unsigned  checked;
	int unsigned  n_range;
	int unsigned  n_full;

	function new();
		foreach (store_bytes[k]) store_bytes[k] = '0;
		gap_lo = 0;
		gap_hi = STORE_BYTES;
		errors = 0;
		checked = 0;
		n_range = 0;
		n_full = 0;
	endfunction

	function int unsigned content_bytes();
		return STORE_BYTES - (gap_hi - gap_lo);
	endfunction

	function int unsigned replies_waiting();
		return replies_due.size();
	endfunction

	// copy bytes across the gap one at a time until it starts at pos
	function void slide_gap(int unsigned pos);
		while (gap_lo > pos) begin
			gap_lo--;
			gap_hi--;
			store_bytes[gap_hi] = store_bytes[gap_lo];
		end
		while (gap_lo < pos) begin
			store_bytes[gap_lo] = store_bytes[gap_hi];
			gap_lo++;
			gap_hi++;
		end
	endfunction

	function void note_edit(logic [1:0] f, logic [15:0] i, logic [7:0] d, logic [16:0] c);
		edit_reply_t r;
		int unsigned len;
		int unsigned idx;
		int unsigned cnt;
		int unsigned phys;
		len = content_bytes();
		idx = 32'(i);
		cnt = 32'(c);
		r.rd = '0;
		r.st = gbe_pkg::ST_OK;
		case (f)
			gbe_pkg::FN_INSERT: begin
				if (idx > len) begin
					r.st = gbe_pkg::ST_RANGE;
				end else if (gap_hi == gap_lo) begin
					r.st = gbe_pkg::ST_FULL;
				end else begin
					slide_gap(idx);
					store_bytes[gap_lo] = d;
					gap_lo++;
				end
			end
			gbe_pkg::FN_REMOVE: begin
				if (idx + cnt > len) begin
					r.st = gbe_pkg::ST_RANGE;
				end else begin
					slide_gap(idx);
					gap_hi += cnt;
				end
			end
			default: begin
				if (idx >= len) begin
					r.st = gbe_pkg::ST_RANGE;
				end else begin
					phys = (idx < gap_lo) ? idx : idx + (gap_hi - gap_lo);
					if (f == gbe_pkg::FN_READ)
						r.rd = store_bytes[phys];
					else
						store_bytes[phys] = d;
				end
			end
		endcase
		r.len = gbe_pkg::LEN_W'(content_bytes());
		replies_due.push_back(r);
	endfunction

	function void check_reply(logic [7:0] rd, logic [1:0] st, logic [16:0] len);
		edit_reply_t want;
		if (replies_due.size() == 0) begin
			$display("%0t: unexpected result: read_byte 0x%02h status %0d length %0d",
				$time, rd, st, len);
			errors++;
			return;
		end
		want = replies_due.pop_front();
		checked++;
		if (want.st == gbe_pkg::ST_RANGE) n_range++;
		if (want.st == gbe_pkg::ST_FULL) n_full++;
		if (rd !== want.rd) begin
			$display("%0t: read_byte expected 0x%02h, actual 0x%02h", $time, want.rd, rd);
			errors++;
		end
		if (st !== want.st) begin
			$display("%0t: status expected %0d, actual %0d", $time, want.st, st);
			errors++;
		end
		if (len !== want.len) begin
			$display("%0t: content_length expected %0d, actual %0d", $time, want.len, len);
			errors++;
		end
	endfunction
endclass

module gap_buffer_engine_tb;
	import gbe_pkg::*;

	// Idle cycles with no transaction on either side before giving up. The
	// slowest single transaction slides the gap across the whole store.
	localparam int unsigned QUIET_LIMIT = 300000;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_CHOPPY,
		SINK_TRICKLE
	} sink_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = '0;
	logic [INDEX_W-1:0]  index = '0;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic [COUNT_W-1:0]  count = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BYTE_W-1:0]   read_byte;
	logic [STAT_W-1:0]   status;
	logic [LEN_W-1:0]    content_length;

	gap_edit_board board = new();

	// sender pacing
	int unsigned burst_left = 0;
	int unsigned edits_sent = 0;

	// receiver pacing
	logic [7:0]  sink_tick = '0;
	sink_mode_t  sink_mode = SINK_OPEN;

	int unsigned quiet_cycles = 0;

	gap_buffer_engine #(
		.CAPACITY(STORE_BYTES)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.index          (index),
		.data_byte      (data_byte),
		.count          (count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_byte      (read_byte),
		.status         (status),
		.content_length (content_length)
	);

	always #10 clk = ~clk;

	// Receiver: switches at random between stall patterns each time its tick
	// counter wraps. The trickle mode raises ready only when the low five tick bits are zero.
	always @(posedge clk) begin
		sink_tick <= sink_tick + 8'd1;
		if (sink_tick == 8'hFF)
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN:    out_ready <= 1'b1;
				SINK_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
				SINK_CHOPPY:  out_ready <= (sink_tick[2:0] < 3'd5);
				SINK_TRICKLE: out_ready <= (sink_tick[4:0] == 5'd0);
				default:      out_ready <= 1'b1;
			endcase
		end
	end

	// Every result transaction is checked against the oldest prediction.
	// Values are sampled at the edge, before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_reply(read_byte, status, content_length);
	end

	// Watchdog: ends a hung run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles == QUIET_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	// Present one transaction and hold it until accepted. Called at a rising
	// edge; returns at the accepting edge with in_valid still high, so the
	// caller either presents the next one or lowers valid in the same step.
	task automatic push_edit(input logic [1:0] f, input logic [15:0] i,
			input logic [7:0] d, input logic [16:0] c);
		in_valid  <= 1'b1;
		func      <= f;
		index     <= i;
		data_byte <= d;
		count     <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_edit(f, i, d, c);
		edits_sent++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Sender in bursts: a random gap ahead of each burst of random length.
	task automatic paced_edit(input logic [1:0] f, input logic [15:0] i,
			input logic [7:0] d, input logic [16:0] c);
		if (burst_left == 0) begin
			pause_sender($urandom_range(1, 8));
			burst_left = $urandom_range(1, 24);
		end
		push_edit(f, i, d, c);
		burst_left--;
	endtask

	// Hold off the sender until every outstanding result has arrived.
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (board.replies_waiting() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned len;
		int unsigned roll;
		int unsigned idx;
		int unsigned cnt;
		int unsigned ins_pct;
		bit          noise;
		logic [1:0]  f;
		logic [7:0]  d;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty buffer corners, every function, edges of each field.
		paced_edit(FN_READ,   16'd0,     8'h00, 17'd0);       // read on empty
		paced_edit(FN_WRITE,  16'd0,     8'hFF, 17'd0);       // overwrite on empty
		paced_edit(FN_REMOVE, 16'd0,     8'h00, 17'd0);       // zero-length remove
		paced_edit(FN_REMOVE, 16'd0,     8'h00, 17'd1);       // run past end
		paced_edit(FN_INSERT, 16'd1,     8'h11, 17'd0);       // insert past end
		paced_edit(FN_INSERT, 16'd0,     8'hA5, 17'd0);
		paced_edit(FN_INSERT, 16'd1,     8'hFF, 17'd0);       // append
		paced_edit(FN_INSERT, 16'd0,     8'h00, 17'd0);       // front, gap slides left
		paced_edit(FN_INSERT, 16'd1,     8'h5A, 17'd0);
		paced_edit(FN_READ,   16'd3,     8'h00, 17'd0);       // past the gap
		paced_edit(FN_READ,   16'd0,     8'h00, 17'd0);
		paced_edit(FN_READ,   16'd4,     8'h00, 17'd0);       // one past end
		paced_edit(FN_WRITE,  16'd2,     8'h3C, 17'd0);
		paced_edit(FN_WRITE,  16'hFFFF,  8'hFF, 17'd0);       // index all ones
		paced_edit(FN_READ,   16'd2,     8'h00, 17'd0);
		paced_edit(FN_REMOVE, 16'd1,     8'h00, 17'd2);
		paced_edit(FN_REMOVE, 16'd1,     8'h00, 17'd0);       // zero count, gap already at the index
		paced_edit(FN_REMOVE, 16'd0,     8'h00, 17'h10000);
		paced_edit(FN_REMOVE, 16'hFFFF,  8'hFF, 17'h1FFFF);   // all ones
		paced_edit(FN_INSERT, 16'hFFFF,  8'h00, 17'd0);
		paced_edit(FN_READ,   16'd1,     8'h00, 17'd0);
		paced_edit(FN_REMOVE, 16'd0,     8'h00, 17'd2);       // back to empty
		paced_edit(FN_INSERT, 16'd0,     8'h81, 17'd0);
		drain_replies();

		// Random edits on a short buffer so gap slides stay short. Mostly
		// legal indexes; one in ten is a raw random value.
		for (int n = 0; n < 450; n++) begin
			if (n % 150 == 149)
				drain_replies();
			len = board.content_bytes();
			roll = $urandom_range(0, 99);
			noise = ($urandom_range(0, 9) == 0);
			ins_pct = (len > 40) ? 20 : 40;
			d = 8'($urandom);
			cnt = 0;
			if (roll < ins_pct) begin
				f = FN_INSERT;
				idx = noise ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, len);
			end else if (roll < 55) begin
				f = FN_REMOVE;
				if (noise) begin
					idx = $urandom_range(0, 16'hFFFF);
					cnt = $urandom_range(0, 17'h1FFFF);
				end else begin
					idx = $urandom_range(0, len);
					cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - idx)
						: $urandom_range(0, (len - idx < 4) ? len - idx : 4);
				end
			end else begin
				f = (roll < 80) ? FN_READ : FN_WRITE;
				if (noise || len == 0)
					idx = $urandom_range(0, 16'hFFFF);
				else
					idx = $urandom_range(0, len - 1);
			end
			paced_edit(f, 16'(idx), d, 17'(cnt));
		end

		drain_replies();
		// catch any stray result after the last one expected
		repeat (40) @(posedge clk);

		$display("Run: %0d edit transactions sent, %0d results checked, empty-buffer corners",
			edits_sent, board.checked);
		$display("Run: %0d out-of-range and %0d full outcomes seen", board.n_range, board.n_full);
		if (board.errors == 0 && board.replies_waiting() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
